[hdl/tdpc_pkg.sv]
// Shared types and constants for the trial-division prime counter.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none
package tdpc_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 32;
  // Widest divisor tried: the first odd d with d*d above 2^31-1 is 46341
  localparam int unsigned DivW   = 16;
  localparam int unsigned RemW   = DivW + 1;
  localparam int unsigned SqW    = 33;
  localparam int unsigned StepW  = 5;

  localparam logic [CountW-1:0] CountMax = '1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture the input transaction, divisor 3
    logic div_init;  // start a remainder for the current divisor
    logic div_step;  // one restoring step of the remainder
    logic div_next;  // move to the next odd divisor
    logic out_load;  // write the result register and the running count
    logic verdict;   // prime flag carried with out_load
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic fast_not;  // negative, below 2, or even and at least 4
    logic fast_prime;// 2 or 3
    logic sq_over;   // divisor squared exceeds the value
    logic step_last; // current step is the final one of the remainder
    logic rem_zero;  // remainder is zero
  } sts_t;

endpackage
`default_nettype wire

[hdl/tdpc_ctrl.sv]
// Controller FSM for the prime counter: sequences trial divisions and output.
// Depends on tdpc_pkg (cmd_t, sts_t).
`default_nettype none
module tdpc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire tdpc_pkg::sts_t sts,
  output tdpc_pkg::cmd_t     cmd
);
  import tdpc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TEST = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       verdict_r, verdict_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    verdict_nxt = verdict_r;
    cmd         = '0;
    cmd.verdict = verdict_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        priority if (sts.fast_not) begin
          verdict_nxt = 1'b0;
          state_nxt   = S_DONE;
        end else if (sts.fast_prime || sts.sq_over) begin
          verdict_nxt = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.step_last) state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.rem_zero) begin
          verdict_nxt = 1'b0;
          state_nxt   = S_DONE;
        end else begin
          cmd.div_next = 1'b1;
          state_nxt    = S_TEST;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      verdict_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      verdict_r   <= verdict_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A finished result with a free output register leaves DONE at once
  a_done_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_valid_r) |=> state_r == S_IDLE)
    else $error("DONE held with a free output register");

  // A remainder always runs into the check state
  a_div_to_chk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && sts.step_last) |=> state_r == S_CHK)
    else $error("remainder did not end in CHK");

endmodule
`default_nettype wire

[hdl/tdpc_dp.sv]
// Datapath for the prime counter: operand, divisor, bit-serial remainder,
// running count and result register. Depends on tdpc_pkg.
`default_nettype none
module tdpc_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic signed [31:0]            in_value,
  input  wire logic                          in_last_item,
  input  wire tdpc_pkg::cmd_t                cmd,
  output tdpc_pkg::sts_t                     sts,
  output logic                               out_is_prime,
  output logic [31:0]                        out_prime_count,
  output logic                               out_batch_end
);
  import tdpc_pkg::*;

  logic [ValueW-1:0] value_r;
  logic              last_r;
  logic [DivW-1:0]   d_r, d_nxt;
  logic [SqW-1:0]    sq_r, sq_nxt;
  logic [RemW-1:0]   rem_r, rem_nxt, rem_sh;
  logic [ValueW-1:0] shr_r, shr_nxt;
  logic [StepW-1:0]  step_r, step_nxt;
  logic [CountW-1:0] count_r, count_nxt, count_new;
  logic              lt2, lt4;

  // Quick classification of the operand
  assign lt2 = (value_r < ValueW'(2));
  assign lt4 = (value_r < ValueW'(4));
  assign sts.fast_not   = value_r[ValueW-1] || lt2 || (!lt4 && !value_r[0]);
  assign sts.fast_prime = !value_r[ValueW-1] && !lt2 && lt4;
  assign sts.sq_over    = (sq_r > {1'b0, value_r});
  assign sts.step_last  = (step_r == '1);
  assign sts.rem_zero   = (rem_r == '0);

  // Divisor and its square: (d+2)^2 = d^2 + 4d + 4
  always_comb begin
    d_nxt  = d_r;
    sq_nxt = sq_r;
    if (cmd.load) begin
      d_nxt  = DivW'(3);
      sq_nxt = SqW'(9);
    end else if (cmd.div_next) begin
      d_nxt  = d_r + DivW'(2);
      sq_nxt = sq_r + {{(SqW-DivW-2){1'b0}}, d_r, 2'b00} + SqW'(4);
    end
  end

  // Restoring remainder, one dividend bit per step
  assign rem_sh = {rem_r[RemW-2:0], shr_r[ValueW-1]};
  always_comb begin
    rem_nxt  = rem_r;
    shr_nxt  = shr_r;
    step_nxt = step_r;
    if (cmd.div_init) begin
      rem_nxt  = '0;
      shr_nxt  = value_r;
      step_nxt = '0;
    end else if (cmd.div_step) begin
      rem_nxt  = (rem_sh >= {1'b0, d_r}) ? rem_sh - {1'b0, d_r} : rem_sh;
      shr_nxt  = {shr_r[ValueW-2:0], 1'b0};
      step_nxt = step_r + StepW'(1);
    end
  end

  // Running count, saturating, cleared after the last transaction of a batch
  assign count_new = (cmd.verdict && count_r != CountMax) ? count_r + CountW'(1) : count_r;
  always_comb begin
    count_nxt = count_r;
    if (cmd.out_load) count_nxt = last_r ? '0 : count_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= unsigned'(in_value);
      last_r  <= in_last_item;
    end
    d_r    <= d_nxt;
    sq_r   <= sq_nxt;
    rem_r  <= rem_nxt;
    shr_r  <= shr_nxt;
    step_r <= step_nxt;
    if (cmd.out_load) begin
      out_is_prime    <= cmd.verdict;
      out_prime_count <= count_new;
      out_batch_end   <= last_r;
    end
  end

  // Trial divisors are odd and at least 3
  a_div_odd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (d_r[0] && d_r >= DivW'(3)))
    else $error("trial divisor not odd or below 3");

  // Partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (rem_r < {1'b0, d_r}))
    else $error("partial remainder out of range");

  // Square tracks the divisor
  a_sq_track: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_init |-> (sq_r == SqW'({16'd0, d_r} * {16'd0, d_r})))
    else $error("divisor square out of step");

endmodule
`default_nettype wire

[hdl/trial_division_prime_counter_core.sv]
// Trial-division prime counter, top level.
//
// Input channel (in_valid / in_stall): one transaction per number, in_value
// (signed 32 bits) and in_last_item, which marks the end of a batch.
// Output channel (out_valid / out_stall): one transaction per input, with
// out_is_prime, out_prime_count (primes so far in the batch, this one
// included, holding at all ones) and out_batch_end (copy of in_last_item).
// The count clears after a result with out_batch_end set.
// One number is worked on at a time. Negative values, 0, 1, even values,
// 2 and 3 resolve without a division. Other values are divided by odd d
// from 3 while d*d <= value, each division on the one bit-serial remainder
// unit, so the time taken grows with the number of divisors tried.
// The result sits in an output register; in_stall drops as soon as it is
// written, so a new number is taken while a result waits under out_stall.
// A finished result waits in DONE only while the register is still full.
// Reset (rst_n low, synchronous) empties the block and zeroes the count.
// Depends on tdpc_pkg, tdpc_ctrl and tdpc_dp.
`default_nettype none
module trial_division_prime_counter_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_value,
  input  wire logic               in_last_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_is_prime,
  output logic [31:0]             out_prime_count,
  output logic                    out_batch_end
);
  import tdpc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tdpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tdpc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_value        (in_value),
    .in_last_item    (in_last_item),
    .cmd             (cmd),
    .sts             (sts),
    .out_is_prime    (out_is_prime),
    .out_prime_count (out_prime_count),
    .out_batch_end   (out_batch_end)
  );

endmodule
`default_nettype wire
